[sv/slt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table package
// Field widths, operation codes and status codes shared by the block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Fixed widths of the channel fields
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes
    localparam t_kind KIND_INSERT = 3'd0;
    localparam t_kind KIND_DELETE = 3'd1;
    localparam t_kind KIND_SEARCH = 3'd2;
    localparam t_kind KIND_REWIND = 3'd3;
    localparam t_kind KIND_NEXT   = 3'd4;

    // Result status codes
    localparam t_status STATUS_OK        = 3'd0;
    localparam t_status STATUS_DUPLICATE = 3'd1;
    localparam t_status STATUS_FULL      = 3'd2;
    localparam t_status STATUS_NOT_FOUND = 3'd3;
    localparam t_status STATUS_EMPTY     = 3'd4;
    localparam t_status STATUS_AT_END    = 3'd5;

endpackage

[sv/slt_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table command channel
// Valid/ready channel carrying one operation word: kind and key value.
// ----------------------------------------------------------------------------
interface slt_in_if;

    logic                              valid;
    logic                              ready;
    slt_pkg::t_kind                    kind;
    logic signed [slt_pkg::KEY_W-1:0]  key_value;

    modport source (output valid, output kind, output key_value, input ready);
    modport sink   (input valid, input kind, input key_value, output ready);

endinterface

[sv/slt_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table result channel
// Valid/ready channel carrying one result word per operation.
// ----------------------------------------------------------------------------
interface slt_out_if;

    logic                                valid;
    logic                                ready;
    slt_pkg::t_status                    status;
    logic [slt_pkg::POS_W-1:0]           position;
    logic signed [slt_pkg::KEY_W-1:0]    entry_value;
    logic [slt_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output status, output position,
                    output entry_value, output entry_count, input ready);
    modport sink   (input valid, input status, input position,
                    input entry_value, input entry_count, output ready);

endinterface

[sv/sorted_list_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table
// Keeps up to CAPACITY signed values in ascending order in a RAM and runs
// insert, delete, search, rewind and read-next operations on it with a
// small sequencer around one compare unit and one RAM read port.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Word fields                                   Handshake
//  ---------  ---  --------------------------------------------  -----------
//  i_item     in   kind, key_value                                valid/ready
//  o_result   out  status, position, entry_value, entry_count     valid/ready
//
//  One operation at a time; i_item.ready is high only while the sequencer idles.
//  Insert, delete and search scan from entry 0, a RAM read state then a compare
//  state per entry; insert then shifts the tail up and delete shifts it down,
//  a read state then a write state per moved entry. Rewind passes only through
//  the dispatch and done states; read-next adds a RAM read and a wait state
//  unless the table is empty or at the end. Each may then wait in the done state
//  for the result slot. The single read port of the entry RAM is why entries
//  are read and moved one at a time.
//  Reset clears count, iterator and result valid; RAM contents need no clearing.
//  A stalled result sits in the output register while the next word is taken.
//
module sorted_list_table #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slt_in_if.sink      i_item,
    slt_out_if.source   o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_END,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_NEXT_RD,
        ST_NEXT_WAIT,
        ST_DONE
    } t_state;

    t_state                       r_state,  n_state;
    slt_pkg::t_kind               r_kind,   n_kind;
    logic [VALUE_WIDTH-1:0]       r_key,    n_key;
    logic [CW-1:0]                r_idx,    n_idx;
    logic                         r_hit,    n_hit;
    logic [CW-1:0]                r_j,      n_j;
    logic [CW-1:0]                r_count,  n_count;
    logic [CW-1:0]                r_iter,   n_iter;
    slt_pkg::t_status             r_status, n_status;
    logic [CW-1:0]                r_pos,    n_pos;
    logic [VALUE_WIDTH-1:0]       r_val,    n_val;

    logic                         r_ovalid,  n_ovalid;
    slt_pkg::t_status             r_ostatus, n_ostatus;
    logic [slt_pkg::POS_W-1:0]    r_opos,    n_opos;
    logic [slt_pkg::KEY_W-1:0]    r_oval,    n_oval;
    logic [slt_pkg::COUNT_W-1:0]  r_ocount,  n_ocount;

    logic [VALUE_WIDTH-1:0]       w_key_in;
    logic [slt_pkg::KEY_W-1:0]    w_val_out;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [VALUE_WIDTH-1:0]       w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [VALUE_WIDTH-1:0]       w_rdata;
    logic [CW-1:0]                w_j_inc;
    logic [CW-1:0]                w_j_dec;

    // Bring the key to storage width and the read value back to word width
    generate
        if (VALUE_WIDTH <= slt_pkg::KEY_W) begin : g_key_narrow
            assign w_key_in = i_item.key_value[VALUE_WIDTH-1:0];
        end else begin : g_key_wide
            assign w_key_in = {{(VALUE_WIDTH - slt_pkg::KEY_W){1'b0}}, i_item.key_value};
        end
        if (VALUE_WIDTH >= slt_pkg::KEY_W) begin : g_val_wide
            assign w_val_out = r_val[slt_pkg::KEY_W-1:0];
        end else begin : g_val_narrow
            assign w_val_out = {{(slt_pkg::KEY_W - VALUE_WIDTH){r_val[VALUE_WIDTH-1]}}, r_val};
        end
    endgenerate

    assign w_j_inc = r_j + CW'(1);
    assign w_j_dec = r_j - CW'(1);

    // Entry storage
    slt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_key     = r_key;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_j       = r_j;
        n_count   = r_count;
        n_iter    = r_iter;
        n_status  = r_status;
        n_pos     = r_pos;
        n_val     = r_val;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_opos    = r_opos;
        n_oval    = r_oval;
        n_ocount  = r_ocount;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = r_key;
        w_raddr   = '0;

        // Drop the result word once taken
        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_kind  = i_item.kind;
                    n_key   = w_key_in;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_status = slt_pkg::STATUS_OK;
                n_pos    = '0;
                n_val    = '0;
                n_idx    = '0;
                n_state  = ST_DONE;
                case (r_kind) inside
                    slt_pkg::KIND_INSERT, slt_pkg::KIND_DELETE, slt_pkg::KIND_SEARCH: begin
                        n_state = ST_SCAN_RD;
                    end
                    slt_pkg::KIND_REWIND: begin
                        n_iter = '0;
                    end
                    slt_pkg::KIND_NEXT: begin
                        if (r_count == '0) begin
                            n_status = slt_pkg::STATUS_EMPTY;
                        end else if (r_iter >= r_count) begin
                            n_status = slt_pkg::STATUS_AT_END;
                        end else begin
                            n_state = ST_NEXT_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN_RD: begin
                if (r_idx >= r_count) begin
                    n_hit   = 1'b0;
                    n_state = ST_SCAN_END;
                end else begin
                    w_raddr = r_idx[AW-1:0];
                    n_state = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                // Advance past smaller entries, stop at the first not smaller
                if ($signed(w_rdata) < $signed(r_key)) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_hit   = (w_rdata == r_key);
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DONE;
                case (r_kind)
                    slt_pkg::KIND_INSERT: begin
                        if (r_hit) begin
                            n_status = slt_pkg::STATUS_DUPLICATE;
                            n_pos    = r_idx;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = slt_pkg::STATUS_FULL;
                        end else begin
                            n_j     = r_count;
                            n_pos   = r_idx;
                            n_state = ST_INS_RD;
                        end
                    end
                    slt_pkg::KIND_DELETE: begin
                        if (!r_hit) begin
                            n_status = slt_pkg::STATUS_NOT_FOUND;
                        end else begin
                            n_j     = r_idx;
                            n_pos   = r_idx;
                            n_state = ST_DEL_RD;
                        end
                    end
                    default: begin
                        if (r_hit) begin
                            n_pos = r_idx;
                        end else begin
                            n_status = slt_pkg::STATUS_NOT_FOUND;
                        end
                    end
                endcase
            end
            ST_INS_RD: begin
                // Shift the tail up one slot, then drop the key into the gap
                if (r_j == r_idx) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[AW-1:0];
                    w_wdata = r_key;
                    n_count = r_count + CW'(1);
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_j_dec[AW-1:0];
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = w_rdata;
                n_j     = w_j_dec;
                n_state = ST_INS_RD;
            end
            ST_DEL_RD: begin
                // Close the gap by moving the tail down one slot
                if (w_j_inc >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_j_inc[AW-1:0];
                    n_state = ST_DEL_WR;
                end
            end
            ST_DEL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[AW-1:0];
                w_wdata = w_rdata;
                n_j     = w_j_inc;
                n_state = ST_DEL_RD;
            end
            ST_NEXT_RD: begin
                w_raddr = r_iter[AW-1:0];
                n_state = ST_NEXT_WAIT;
            end
            ST_NEXT_WAIT: begin
                n_pos   = r_iter;
                n_val   = w_rdata;
                n_iter  = r_iter + CW'(1);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the result slot is free, then load it
                if (!r_ovalid || o_result.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_opos    = slt_pkg::POS_W'(r_pos);
                    n_oval    = w_val_out;
                    n_ocount  = slt_pkg::COUNT_W'(r_count);
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_iter   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_iter    <= n_iter;
            r_ovalid  <= n_ovalid;
            r_kind    <= n_kind;
            r_key     <= n_key;
            r_idx     <= n_idx;
            r_hit     <= n_hit;
            r_j       <= n_j;
            r_status  <= n_status;
            r_pos     <= n_pos;
            r_val     <= n_val;
            r_ostatus <= n_ostatus;
            r_opos    <= n_opos;
            r_oval    <= n_oval;
            r_ocount  <= n_ocount;
        end
    end

    assign i_item.ready         = (r_state == ST_IDLE);
    assign o_result.valid       = r_ovalid;
    assign o_result.status      = r_ostatus;
    assign o_result.position    = r_opos;
    assign o_result.entry_value = r_oval;
    assign o_result.entry_count = r_ocount;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == ST_INS_RD || $past(r_state) == ST_DEL_RD))
        else $error("entry count changed outside a shift");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_INS_RD || r_state == ST_INS_WR || r_state == ST_DEL_WR))
        else $error("RAM written outside a shift");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside done state");

    a_iter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEXT_WAIT) |=> (r_iter == $past(r_iter) + CW'(1)))
        else $error("iterator did not advance after read");
`endif

endmodule

[sv/slt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table RAM
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/sorted_list_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Sends insert, delete, search, rewind and read-next words to the table and
// checks every result word against a behavioral copy of the table kept here.
// A directed pass covers the value extremes and every status but full. Fill and drain
// rounds push the table to full and back to empty. Random phases with shifting
// operation mixes follow, and a final burst runs with no idling on either side.
// ----------------------------------------------------------------------------
module sorted_list_table_tb;

    localparam int CAPACITY     = 64;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

    typedef logic signed [slt_pkg::KEY_W-1:0] t_key;
    typedef logic [slt_pkg::KEY_W-1:0]        t_word;

    typedef struct {
        slt_pkg::t_status              status;
        logic [slt_pkg::POS_W-1:0]     position;
        t_key                          entry_value;
        logic [slt_pkg::COUNT_W-1:0]   entry_count;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    slt_in_if  item_ch ();
    slt_out_if result_ch ();

    sorted_list_table #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (slt_pkg::KEY_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    // Behavioral copy of the table
    t_key     table_vals [CAPACITY];
    int       table_count;
    int       iter_pos;

    // Outcomes waiting for their result word
    t_outcome pending_outcomes [$];

    int       mismatch_count;
    int       cycle_count;
    int       op_tally [8];
    int       status_tally [8];
    bit       send_idle_on;
    bit       recv_stall_on;
    int       stall_left;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Apply one operation to the table copy and return the result it gives
    function automatic t_outcome table_op_outcome(slt_pkg::t_kind op, t_key key);
        t_outcome res;
        int       slot;
        int       j;
        bit       hit;
        res.status      = slt_pkg::STATUS_OK;
        res.position    = '0;
        res.entry_value = '0;
        slot = 0;
        while (slot < table_count && table_vals[slot] < key) slot++;
        hit = (slot < table_count) && (table_vals[slot] == key);
        case (op)
            slt_pkg::KIND_INSERT: begin
                if (hit) begin
                    res.status   = slt_pkg::STATUS_DUPLICATE;
                    res.position = slt_pkg::POS_W'(slot);
                end else if (table_count >= CAPACITY) begin
                    res.status = slt_pkg::STATUS_FULL;
                end else begin
                    for (j = table_count; j > slot; j--) table_vals[j] = table_vals[j-1];
                    table_vals[slot] = key;
                    table_count++;
                    res.position = slt_pkg::POS_W'(slot);
                end
            end
            slt_pkg::KIND_DELETE: begin
                if (!hit) begin
                    res.status = slt_pkg::STATUS_NOT_FOUND;
                end else begin
                    for (j = slot; j < table_count - 1; j++) table_vals[j] = table_vals[j+1];
                    table_count--;
                    res.position = slt_pkg::POS_W'(slot);
                end
            end
            slt_pkg::KIND_SEARCH: begin
                if (hit) res.position = slt_pkg::POS_W'(slot);
                else     res.status   = slt_pkg::STATUS_NOT_FOUND;
            end
            slt_pkg::KIND_REWIND: begin
                iter_pos = 0;
            end
            slt_pkg::KIND_NEXT: begin
                if (table_count == 0) begin
                    res.status = slt_pkg::STATUS_EMPTY;
                end else if (iter_pos >= table_count) begin
                    res.status = slt_pkg::STATUS_AT_END;
                end else begin
                    res.position    = slt_pkg::POS_W'(iter_pos);
                    res.entry_value = table_vals[iter_pos];
                    iter_pos++;
                end
            end
            default: ;
        endcase
        res.entry_count = slt_pkg::COUNT_W'(table_count);
        return res;
    endfunction

    // Compare one field of a result word
    task automatic check_field(string field, t_word want, t_word got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Predict on each accepted command word, check each accepted result word
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                pending_outcomes.push_back(table_op_outcome(item_ch.kind, item_ch.key_value));
                op_tally[item_ch.kind]++;
            end
            if (result_ch.valid && result_ch.ready) begin
                if (pending_outcomes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result word: expected none, actual status %0d",
                             $time, result_ch.status);
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", t_word'(want.status), t_word'(result_ch.status));
                    check_field("position", t_word'(want.position),
                                t_word'(result_ch.position));
                    check_field("entry_value", t_word'(want.entry_value),
                                t_word'(result_ch.entry_value));
                    check_field("entry_count", t_word'(want.entry_count),
                                t_word'(result_ch.entry_count));
                    status_tally[want.status]++;
                end
            end
        end
    end

    // Drive result ready with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (recv_stall_on && $urandom_range(0, 4) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 10);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one command word, after an optional idle burst
    task automatic send_word(slt_pkg::t_kind op, t_key key);
        int gap;
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= op;
        item_ch.key_value <= key;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Choose a key: mostly stored values and a narrow window, some extremes
    function automatic t_key pick_key();
        int roll;
        int held;
        roll = $urandom_range(0, 99);
        held = table_count;
        if (roll < 35 && held > 0) return table_vals[$urandom_range(0, held - 1)];
        if (roll < 75) return t_key'(int'($urandom_range(0, 199)) - 100);
        if (roll < 85) begin
            case ($urandom_range(0, 5))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 32'sh7fff_fffe;
                3:       return 32'sh8000_0001;
                4:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return t_key'($urandom);
    endfunction

    // Choose an operation from the given weights
    function automatic slt_pkg::t_kind pick_op(int w_ins, int w_del, int w_find, int w_walk);
        int roll;
        roll = $urandom_range(0, w_ins + w_del + w_find + w_walk - 1);
        if (roll < w_ins) return slt_pkg::KIND_INSERT;
        roll -= w_ins;
        if (roll < w_del) return slt_pkg::KIND_DELETE;
        roll -= w_del;
        if (roll < w_find) return slt_pkg::KIND_SEARCH;
        return ($urandom_range(0, 5) == 0) ? slt_pkg::KIND_REWIND : slt_pkg::KIND_NEXT;
    endfunction

    task automatic run_phase(int words, int w_ins, int w_del, int w_find, int w_walk);
        int n;
        for (n = 0; n < words; n++) send_word(pick_op(w_ins, w_del, w_find, w_walk), pick_key());
    endtask

    // Extremes, every status but full, and the iterator running past a shrinking table
    task automatic test_directed_edges();
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        send_word(slt_pkg::KIND_SEARCH, 32'sd0);
        send_word(slt_pkg::KIND_DELETE, 32'sd0);
        send_word(slt_pkg::KIND_INSERT, 32'sd0);
        send_word(slt_pkg::KIND_INSERT, 32'sh7fff_ffff);
        send_word(slt_pkg::KIND_INSERT, 32'sh8000_0000);
        send_word(slt_pkg::KIND_INSERT, -32'sd1);
        send_word(slt_pkg::KIND_INSERT, 32'sd0);
        send_word(slt_pkg::KIND_SEARCH, 32'sh8000_0000);
        send_word(slt_pkg::KIND_SEARCH, 32'sh7fff_ffff);
        send_word(slt_pkg::KIND_SEARCH, 32'sd5);
        send_word(slt_pkg::KIND_REWIND, t_key'($urandom));
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        // shift entries under the iterator
        send_word(slt_pkg::KIND_DELETE, 32'sh8000_0000);
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        send_word(slt_pkg::KIND_DELETE, -32'sd1);
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        send_word(slt_pkg::KIND_DELETE, 32'sh7fff_ffff);
        send_word(slt_pkg::KIND_DELETE, 32'sd0);
        send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        send_word(slt_pkg::KIND_INSERT, 32'sh5555_5555);
        send_word(slt_pkg::KIND_INSERT, 32'shaaaa_aaaa);
        send_word(slt_pkg::KIND_REWIND, t_key'($urandom));
    endtask

    // Fill to capacity, hit the full table, walk it, then drain it to empty
    task automatic test_fill_and_drain();
        int round;
        int guard;
        int held;
        for (round = 0; round < 2; round++) begin
            guard = 0;
            while (table_count < CAPACITY && guard < 4 * CAPACITY) begin
                send_word(slt_pkg::KIND_INSERT, (round == 0) ? t_key'($urandom) : pick_key());
                guard++;
            end
            repeat (3) send_word(slt_pkg::KIND_INSERT, t_key'($urandom));
            held = table_count;
            if (held > 0)
                send_word(slt_pkg::KIND_INSERT, table_vals[$urandom_range(0, held - 1)]);
            send_word(slt_pkg::KIND_REWIND, t_key'($urandom));
            repeat (CAPACITY + 2) send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
            repeat (8) send_word(slt_pkg::KIND_SEARCH, pick_key());
            guard = 0;
            while (table_count > 0 && guard < 4 * CAPACITY) begin
                held = table_count;
                send_word(slt_pkg::KIND_DELETE, table_vals[$urandom_range(0, held - 1)]);
                guard++;
            end
            send_word(slt_pkg::KIND_NEXT, t_key'($urandom));
        end
    endtask

    // Random phases with shifting operation mixes and idling
    task automatic test_random_mix();
        int phase;
        for (phase = 0; phase < 12; phase++) begin
            send_idle_on  = ($urandom_range(0, 3) != 0);
            recv_stall_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       run_phase(100, 60, 10, 15, 15);
                1:       run_phase(100, 10, 55, 20, 15);
                2:       run_phase(100, 30, 30, 25, 15);
                default: run_phase(100, 15, 10, 10, 65);
            endcase
        end
    endtask

    // Back-to-back words with both sides always ready
    task automatic test_back_to_back();
        send_idle_on  = 1'b0;
        recv_stall_on = 1'b0;
        run_phase(250, 30, 25, 25, 20);
    endtask

    initial begin
        i_rst_n               = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.kind          = slt_pkg::KIND_INSERT;
        item_ch.key_value     = '0;
        result_ch.ready       = 1'b0;
        table_count           = 0;
        iter_pos              = 0;
        mismatch_count        = 0;
        cycle_count           = 0;
        stall_left            = 0;
        send_idle_on          = 1'b1;
        recv_stall_on         = 1'b1;
        foreach (op_tally[k]) op_tally[k] = 0;
        foreach (status_tally[k]) status_tally[k] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_fill_and_drain();
        test_random_mix();
        test_back_to_back();
        item_ch.valid <= 1'b0;

        // wait out the last results, then watch for strays
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // flag any result that never arrived
        if (pending_outcomes.size() != 0) begin
            mismatch_count++;
            $display("%0t ns: missing result words: expected 0 outstanding, actual %0d",
                     $time, pending_outcomes.size());
        end

        $display("Run covered %0d insert, %0d delete, %0d search, %0d rewind, %0d next words.",
                 op_tally[slt_pkg::KIND_INSERT], op_tally[slt_pkg::KIND_DELETE],
                 op_tally[slt_pkg::KIND_SEARCH], op_tally[slt_pkg::KIND_REWIND],
                 op_tally[slt_pkg::KIND_NEXT]);
        $display("Statuses: ok %0d, duplicate %0d, full %0d, not found %0d, empty %0d, end %0d.",
                 status_tally[slt_pkg::STATUS_OK], status_tally[slt_pkg::STATUS_DUPLICATE],
                 status_tally[slt_pkg::STATUS_FULL], status_tally[slt_pkg::STATUS_NOT_FOUND],
                 status_tally[slt_pkg::STATUS_EMPTY], status_tally[slt_pkg::STATUS_AT_END]);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/slt_pkg.sv
sv/slt_in_if.sv
sv/slt_out_if.sv
sv/slt_ram.sv
sv/sorted_list_table.sv
tb/sorted_list_table_tb.sv
